>>> hdl/pnpc_pkg.sv
// Shared constants and types for the point-to-pixel projection and normal coloring block.
package pnpc_pkg;

   localparam int DEF_IMAGE_WIDTH  = 640;
   localparam int DEF_IMAGE_HEIGHT = 480;

   localparam int POS_W   = 32;   // point coordinates, 16 fraction bits
   localparam int NORM_W  = 16;   // normal components, 14 fraction bits
   localparam int REG_W   = 20;   // camera registers, 8 fraction bits
   localparam int COLOR_W = 8;

   // quotient bits kept by the divider; covers any image edge up to 4096
   localparam int QUO_BITS = 13;

   // projection: mult, add, abs, range check, QUO_BITS divide steps, clamp
   // color: square, sum, two stages per color bit
   localparam int PIPE_DEPTH = 5 + QUO_BITS;

   localparam int COLOR_SCALE = 255;
   localparam logic [COLOR_W-1:0] COLOR_MID = COLOR_W'(128);

   localparam int CSR_ADDR_W = 2;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_FOCAL_X  = 2'd0,
      REG_FOCAL_Y  = 2'd1,
      REG_CENTRE_X = 2'd2,
      REG_CENTRE_Y = 2'd3
   } csr_reg_type;

   localparam logic [REG_W-1:0] FOCAL_X_RST  = 20'd149152;
   localparam logic [REG_W-1:0] FOCAL_Y_RST  = 20'd149169;
   localparam logic [REG_W-1:0] CENTRE_X_RST = 20'd80139;
   localparam logic [REG_W-1:0] CENTRE_Y_RST = 20'd61042;

endpackage

>>> hdl/point_normal_to_pixel_color.sv
// Top level: projects a 3D point to a pixel and colors it from its surface normal.
//
// Input words arrive on req_* (valid/ready) with a point (x, y, z), its normal and
// point_ok. Each word gives one rsp_* word: pixel column and row, red, green, blue
// and write_pixel. write_pixel is 0, with all other fields 0, when point_ok is 0
// or z is 0. A zero normal gives 128 on all three colors.
// Camera registers are written through csr_* (valid/ready, csr_ready always high),
// addressed focal_x, focal_y, centre_x, centre_y; write them only while idle.
// The pipeline is 18 stages deep: multiply, add and range check, then the 13-step
// divider, one quotient bit per step, and a clamp; the color path searches the
// color code bit by bit alongside. Throughput is one word per cycle while the
// receiver does not stall. Each stage carries a valid bit; when the receiver
// stalls, words close up behind the last stage and req_ready drops only once all
// 18 stages hold a word.
// Reset empties the pipeline and restores the camera registers to their defaults.
module point_normal_to_pixel_color #(
   parameter int IMAGE_WIDTH  = pnpc_pkg::DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = pnpc_pkg::DEF_IMAGE_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [pnpc_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [pnpc_pkg::POS_W-1:0]   req_pos_y,
   input  logic signed [pnpc_pkg::POS_W-1:0]   req_pos_z,
   input  logic signed [pnpc_pkg::NORM_W-1:0]  req_norm_x,
   input  logic signed [pnpc_pkg::NORM_W-1:0]  req_norm_y,
   input  logic signed [pnpc_pkg::NORM_W-1:0]  req_norm_z,
   input  logic                                req_point_ok,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [$clog2(IMAGE_WIDTH)-1:0]      rsp_pixel_col,
   output logic [$clog2(IMAGE_HEIGHT)-1:0]     rsp_pixel_row,
   output logic [pnpc_pkg::COLOR_W-1:0]        rsp_red,
   output logic [pnpc_pkg::COLOR_W-1:0]        rsp_green,
   output logic [pnpc_pkg::COLOR_W-1:0]        rsp_blue,
   output logic                                rsp_write_pixel,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pnpc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [pnpc_pkg::REG_W-1:0]          csr_wdata
);

   localparam int D     = pnpc_pkg::PIPE_DEPTH;
   localparam int COL_W = $clog2(IMAGE_WIDTH);
   localparam int ROW_W = $clog2(IMAGE_HEIGHT);

   logic [pnpc_pkg::REG_W-1:0] focal_x_ff, focal_y_ff, centre_x_ff, centre_y_ff;
   logic [D-1:0]               ld, v_ff, wr_ff;
   logic [COL_W-1:0]           col;
   logic [ROW_W-1:0]           row;
   logic signed [pnpc_pkg::NORM_W-1:0] norm [3];
   logic [pnpc_pkg::COLOR_W-1:0]       rgb  [3];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= pnpc_pkg::FOCAL_X_RST;
         focal_y_ff  <= pnpc_pkg::FOCAL_Y_RST;
         centre_x_ff <= pnpc_pkg::CENTRE_X_RST;
         centre_y_ff <= pnpc_pkg::CENTRE_Y_RST;
      end else if (csr_valid) begin
         unique case (pnpc_pkg::csr_reg_type'(csr_addr))
            pnpc_pkg::REG_FOCAL_X:  focal_x_ff  <= csr_wdata;
            pnpc_pkg::REG_FOCAL_Y:  focal_y_ff  <= csr_wdata;
            pnpc_pkg::REG_CENTRE_X: centre_x_ff <= csr_wdata;
            pnpc_pkg::REG_CENTRE_Y: centre_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a stage loads when it or any stage after it is empty, or the output drains
   always_comb begin
      for (int k = 0; k < D; k++) begin
         ld[k] = rsp_ready || ((~v_ff >> k) != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (ld[0]) v_ff[0] <= req_valid;
         for (int k = 1; k < D; k++) begin
            if (ld[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) wr_ff[0] <= req_point_ok && (req_pos_z != '0);
      for (int k = 1; k < D; k++) begin
         if (ld[k]) wr_ff[k] <= wr_ff[k-1];
      end
   end

   assign req_ready = ld[0];

   pnpc_proj #(.LIMIT(IMAGE_WIDTH - 1), .OUT_W(COL_W)) u_proj_col (
      .clock  (clock),
      .ld     (ld),
      .pos    (req_pos_x),
      .depth  (req_pos_z),
      .focal  (focal_x_ff),
      .centre (centre_x_ff),
      .pix    (col)
   );

   pnpc_proj #(.LIMIT(IMAGE_HEIGHT - 1), .OUT_W(ROW_W)) u_proj_row (
      .clock  (clock),
      .ld     (ld),
      .pos    (req_pos_y),
      .depth  (req_pos_z),
      .focal  (focal_y_ff),
      .centre (centre_y_ff),
      .pix    (row)
   );

   assign norm[0] = req_norm_x;
   assign norm[1] = req_norm_y;
   assign norm[2] = req_norm_z;

   pnpc_color u_color (
      .clock (clock),
      .ld    (ld),
      .norm  (norm),
      .color (rgb)
   );

   assign rsp_valid       = v_ff[D-1];
   assign rsp_write_pixel = wr_ff[D-1];
   assign rsp_pixel_col   = wr_ff[D-1] ? col    : '0;
   assign rsp_pixel_row   = wr_ff[D-1] ? row    : '0;
   assign rsp_red         = wr_ff[D-1] ? rgb[0] : '0;
   assign rsp_green       = wr_ff[D-1] ? rgb[1] : '0;
   assign rsp_blue        = wr_ff[D-1] ? rgb[2] : '0;

endmodule

>>> hdl/pnpc_proj.sv
// One projection axis: (p*f + c*z) / (256*z), rounded, mirrored and clamped.
module pnpc_proj #(
   parameter int LIMIT = pnpc_pkg::DEF_IMAGE_WIDTH - 1,
   parameter int OUT_W = $clog2(pnpc_pkg::DEF_IMAGE_WIDTH)
) (
   input  logic                                clock,
   input  logic [pnpc_pkg::PIPE_DEPTH-1:0]     ld,
   input  logic signed [pnpc_pkg::POS_W-1:0]   pos,
   input  logic signed [pnpc_pkg::POS_W-1:0]   depth,
   input  logic [pnpc_pkg::REG_W-1:0]          focal,
   input  logic [pnpc_pkg::REG_W-1:0]          centre,
   output logic [OUT_W-1:0]                    pix
);

   localparam int PW   = pnpc_pkg::POS_W;
   localparam int MW   = PW + pnpc_pkg::REG_W + 1;   // signed product
   localparam int SW   = MW + 1;                     // signed sum
   localparam int AW   = MW;                         // |num|
   localparam int NW   = AW + 1;                     // 2|num| + 256|z|
   localparam int DW   = PW + 9;                     // 512|z|
   localparam int QB   = pnpc_pkg::QUO_BITS;
   localparam int DIV0 = 4;
   localparam int LAST = DIV0 + QB;
   localparam logic [QB-1:0] LIM_Q = QB'(LIMIT);

   logic signed [MW-1:0] pf_in, cz_in;
   logic signed [MW-1:0] pf_ff, cz_ff;
   logic signed [PW-1:0] z_ff;
   logic signed [SW-1:0] num_ff;
   logic [PW-1:0]        az_ff, az_in;
   logic [AW-1:0]        an_in;
   logic [NW-1:0]        n2_ff, n3_ff;
   logic [DW-1:0]        d2_ff, d3_ff;
   logic                 ovf_in, ovf_ff;
   logic [NW-1:0]        rem_ff [QB];
   logic [QB-1:0]        quo_ff [QB];
   logic [DW-1:0]        dd_ff  [QB];
   logic                 ov_ff  [QB];
   logic [OUT_W-1:0]     pix_ff;

   assign pf_in  = pos * $signed({1'b0, focal});
   assign cz_in  = $signed({1'b0, centre}) * depth;
   assign az_in  = z_ff[PW-1] ? PW'(-z_ff) : PW'(z_ff);
   assign an_in  = num_ff[SW-1] ? AW'(-num_ff) : AW'(num_ff);
   // quotient of 2^QB or more always clamps
   assign ovf_in = {1'b0, n2_ff} >= {1'b0, d2_ff, {QB{1'b0}}};

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         pf_ff <= pf_in;
         cz_ff <= cz_in;
         z_ff  <= depth;
      end
      if (ld[1]) begin
         num_ff <= SW'(pf_ff) + SW'(cz_ff);
         az_ff  <= az_in;
      end
      if (ld[2]) begin
         n2_ff <= {an_in, 1'b0} + NW'({az_ff, 8'b0});
         d2_ff <= {az_ff, 9'b0};
      end
      if (ld[3]) begin
         n3_ff  <= n2_ff;
         d3_ff  <= d2_ff;
         ovf_ff <= ovf_in;
      end
   end

   // restoring divide, one quotient bit per stage, MSB first
   for (genvar j = 0; j < QB; j++) begin : g_div
      logic [NW-1:0] rem_src, trial;
      logic [DW-1:0] d_src;
      logic [QB-1:0] q_src;
      logic          ov_src;

      if (j == 0) begin : g_first
         assign rem_src = n3_ff;
         assign d_src   = d3_ff;
         assign q_src   = '0;
         assign ov_src  = ovf_ff;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign d_src   = dd_ff[j-1];
         assign q_src   = quo_ff[j-1];
         assign ov_src  = ov_ff[j-1];
      end

      assign trial = NW'(d_src) << (QB - 1 - j);

      always_ff @(posedge clock) begin
         if (ld[DIV0+j]) begin
            if (rem_src >= trial) begin
               rem_ff[j] <= rem_src - trial;
               quo_ff[j] <= q_src | (QB'(1) << (QB - 1 - j));
            end else begin
               rem_ff[j] <= rem_src;
               quo_ff[j] <= q_src;
            end
            dd_ff[j] <= d_src;
            ov_ff[j] <= ov_src;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[LAST]) begin
         if (ov_ff[QB-1] || quo_ff[QB-1] > LIM_Q) begin
            pix_ff <= OUT_W'(LIMIT);
         end else begin
            pix_ff <= quo_ff[QB-1][OUT_W-1:0];
         end
      end
   end

   assign pix = pix_ff;

endmodule

>>> hdl/pnpc_color.sv
// Normal to RGB: exact round((c/|n|+1)/2*255) by a bit-serial search over the color code.
module pnpc_color (
   input  logic                                 clock,
   input  logic [pnpc_pkg::PIPE_DEPTH-1:0]      ld,
   input  logic signed [pnpc_pkg::NORM_W-1:0]   norm  [3],
   output logic [pnpc_pkg::COLOR_W-1:0]         color [3]
);

   localparam int NW    = pnpc_pkg::NORM_W;
   localparam int CW    = pnpc_pkg::COLOR_W;
   localparam int QW    = 2 * NW - 1;           // one square
   localparam int SUMW  = QW + 1;               // sum of three squares
   localparam int BW    = QW + 2 * CW;          // (255c)^2
   localparam int AW    = CW + 2;               // a = 2k - 256, signed
   localparam int ASQW  = 2 * CW;
   localparam int PW    = SUMW + ASQW;
   localparam int SCALE_SQ = pnpc_pkg::COLOR_SCALE * pnpc_pkg::COLOR_SCALE;

   logic [QW-1:0]   sq0_ff  [3];
   logic            neg0_ff [3];
   logic [SUMW-1:0] s1_ff;
   logic [BW-1:0]   bb1_ff  [3];
   logic            neg1_ff [3];

   // search step t: A stage forms the trial code and a^2, B stage decides
   logic [SUMW-1:0] as_ff    [CW];
   logic [BW-1:0]   abb_ff   [CW][3];
   logic            abneg_ff [CW][3];
   logic [CW-1:0]   ak_ff    [CW][3];
   logic [CW-1:0]   acand_ff [CW][3];
   logic [ASQW-1:0] asq_ff   [CW][3];
   logic            apos_ff  [CW][3];
   logic            aneg_ff  [CW][3];
   logic [SUMW-1:0] bs_ff    [CW];
   logic [BW-1:0]   bbb_ff   [CW][3];
   logic            bbneg_ff [CW][3];
   logic [CW-1:0]   bk_ff    [CW][3];

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         for (int l = 0; l < 3; l++) begin
            sq0_ff[l]  <= QW'(norm[l] * norm[l]);
            neg0_ff[l] <= norm[l][NW-1];
         end
      end
      if (ld[1]) begin
         s1_ff <= SUMW'(sq0_ff[0]) + SUMW'(sq0_ff[1]) + SUMW'(sq0_ff[2]);
         for (int l = 0; l < 3; l++) begin
            bb1_ff[l]  <= BW'(sq0_ff[l]) * BW'(SCALE_SQ);
            neg1_ff[l] <= neg0_ff[l];
         end
      end
   end

   for (genvar t = 0; t < CW; t++) begin : g_step
      logic [SUMW-1:0] s_src;
      logic [BW-1:0]   bb_src  [3];
      logic            bn_src  [3];
      logic [CW-1:0]   k_src   [3];

      if (t == 0) begin : g_first
         assign s_src = s1_ff;
         for (genvar l = 0; l < 3; l++) begin : g_lane
            assign bb_src[l] = bb1_ff[l];
            assign bn_src[l] = neg1_ff[l];
            assign k_src[l]  = '0;
         end
      end else begin : g_next
         assign s_src = bs_ff[t-1];
         for (genvar l = 0; l < 3; l++) begin : g_lane
            assign bb_src[l] = bbb_ff[t-1][l];
            assign bn_src[l] = bbneg_ff[t-1][l];
            assign k_src[l]  = bk_ff[t-1][l];
         end
      end

      always_ff @(posedge clock) begin
         logic [CW-1:0]        cand;
         logic signed [AW-1:0] a;
         logic [CW-1:0]        a_abs;
         if (ld[2+2*t]) begin
            as_ff[t] <= s_src;
            for (int l = 0; l < 3; l++) begin
               cand  = k_src[l] | (CW'(1) << (CW - 1 - t));
               a     = $signed({1'b0, cand, 1'b0}) - $signed(AW'(1) << CW);
               a_abs = a[AW-1] ? CW'(-a) : CW'(a);
               abb_ff[t][l]   <= bb_src[l];
               abneg_ff[t][l] <= bn_src[l];
               ak_ff[t][l]    <= k_src[l];
               acand_ff[t][l] <= cand;
               asq_ff[t][l]   <= ASQW'(a_abs) * ASQW'(a_abs);
               apos_ff[t][l]  <= !a[AW-1] && (a != '0);
               aneg_ff[t][l]  <= a[AW-1];
            end
         end
      end

      always_ff @(posedge clock) begin
         logic [PW-1:0] prod;
         logic          pass;
         if (ld[3+2*t]) begin
            bs_ff[t] <= as_ff[t];
            for (int l = 0; l < 3; l++) begin
               prod = PW'(as_ff[t]) * PW'(asq_ff[t][l]);
               // sqrt(s)*a <= 255c, decided on squares with the signs apart
               if (!apos_ff[t][l] && !abneg_ff[t][l]) begin
                  pass = 1'b1;
               end else if (!aneg_ff[t][l] && abneg_ff[t][l]) begin
                  pass = 1'b0;
               end else if (apos_ff[t][l]) begin
                  pass = PW'(prod) <= PW'(abb_ff[t][l]);
               end else begin
                  pass = PW'(prod) >= PW'(abb_ff[t][l]);
               end
               bbb_ff[t][l]   <= abb_ff[t][l];
               bbneg_ff[t][l] <= abneg_ff[t][l];
               if ((t == CW - 1) && (as_ff[t] == '0)) begin
                  bk_ff[t][l] <= pnpc_pkg::COLOR_MID;   // zero normal
               end else if (pass) begin
                  bk_ff[t][l] <= acand_ff[t][l];
               end else begin
                  bk_ff[t][l] <= ak_ff[t][l];
               end
            end
         end
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_out
      assign color[l] = bk_ff[CW-1][l];
   end

endmodule

>>> hdl/pnpc_check.sv
// Port-level checks for the projection block, bound to the top level.
module pnpc_check #(
   parameter int IMAGE_WIDTH  = pnpc_pkg::DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = pnpc_pkg::DEF_IMAGE_HEIGHT
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [$clog2(IMAGE_WIDTH)-1:0]      rsp_pixel_col,
   input logic [$clog2(IMAGE_HEIGHT)-1:0]     rsp_pixel_row,
   input logic [pnpc_pkg::COLOR_W-1:0]        rsp_red,
   input logic [pnpc_pkg::COLOR_W-1:0]        rsp_green,
   input logic [pnpc_pkg::COLOR_W-1:0]        rsp_blue,
   input logic                                rsp_write_pixel
);

   localparam int COL_W = $clog2(IMAGE_WIDTH);
   localparam int ROW_W = $clog2(IMAGE_HEIGHT);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_col)
         && $stable(rsp_pixel_row) && $stable(rsp_red) && $stable(rsp_write_pixel))
      else $error("rsp word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_pixel |-> rsp_pixel_col == '0 && rsp_pixel_row == '0
         && rsp_red == '0 && rsp_green == '0 && rsp_blue == '0)
      else $error("skipped word carries nonzero fields");

   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pixel_col <= COL_W'(IMAGE_WIDTH - 1)
         && rsp_pixel_row <= ROW_W'(IMAGE_HEIGHT - 1))
      else $error("pixel outside image");

   a_no_block: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output stage");

endmodule

bind point_normal_to_pixel_color pnpc_check #(
   .IMAGE_WIDTH  (IMAGE_WIDTH),
   .IMAGE_HEIGHT (IMAGE_HEIGHT)
) u_pnpc_check (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_pixel_col   (rsp_pixel_col),
   .rsp_pixel_row   (rsp_pixel_row),
   .rsp_red         (rsp_red),
   .rsp_green       (rsp_green),
   .rsp_blue        (rsp_blue),
   .rsp_write_pixel (rsp_write_pixel)
);

>>> tb/sv/pnpc_checker.sv
// Checker: predicts each projected pixel and color word and compares it with the block output.
`timescale 1ns / 1ps
module pnpc_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [pnpc_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [pnpc_pkg::POS_W-1:0]   req_pos_y,
   input  logic signed [pnpc_pkg::POS_W-1:0]   req_pos_z,
   input  logic signed [pnpc_pkg::NORM_W-1:0]  req_norm_x,
   input  logic signed [pnpc_pkg::NORM_W-1:0]  req_norm_y,
   input  logic signed [pnpc_pkg::NORM_W-1:0]  req_norm_z,
   input  logic                                req_point_ok,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [9:0]                          rsp_pixel_col,
   input  logic [8:0]                          rsp_pixel_row,
   input  logic [pnpc_pkg::COLOR_W-1:0]        rsp_red,
   input  logic [pnpc_pkg::COLOR_W-1:0]        rsp_green,
   input  logic [pnpc_pkg::COLOR_W-1:0]        rsp_blue,
   input  logic                                rsp_write_pixel,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [pnpc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [pnpc_pkg::REG_W-1:0]          csr_wdata,
   output int                                  fail_count,
   output int                                  pending
);

   typedef struct packed {
      logic [9:0]                   col;
      logic [8:0]                   row;
      logic [pnpc_pkg::COLOR_W-1:0] r;
      logic [pnpc_pkg::COLOR_W-1:0] g;
      logic [pnpc_pkg::COLOR_W-1:0] b;
      logic                         wr;
   } pixel_word_type;

   pixel_word_type pixel_queue[$];
   logic [pnpc_pkg::REG_W-1:0] focal_x, focal_y, centre_x, centre_y;

   assign pending = pixel_queue.size();

   function automatic longint project_axis(longint p, longint z, longint f, longint c,
                                           longint lim);
      longint num, den, q;
      num = p * f + c * z;
      den = z * 256;
      if (num < 0) num = -num;
      if (den < 0) den = -den;
      q = (2 * num + den) / (2 * den);
      return (q > lim) ? lim : q;
   endfunction

   // sqrt(s)*a <= b, decided on integers
   function automatic bit root_le(longint s, longint a, longint b);
      if (a <= 0 && b >= 0) return 1;
      if (a >= 0 && b < 0) return 0;
      if (a > 0) return s * a * a <= b * b;
      return s * a * a >= b * b;
   endfunction

   function automatic logic [7:0] shade(longint c, longint s);
      int k;
      k = 0;
      if (s == 0) return pnpc_pkg::COLOR_MID;
      for (int i = 1; i <= 255; i++) begin
         if (!root_le(s, 2 * i - 256, 255 * c)) break;
         k = i;
      end
      return k[7:0];
   endfunction

   function automatic pixel_word_type predict_pixel(longint px, longint py, longint pz,
                                                    longint nx, longint ny, longint nz,
                                                    bit ok);
      pixel_word_type w;
      longint s;
      w = '0;
      if (!ok || pz == 0) return w;
      w.col = 10'(project_axis(px, pz, focal_x, centre_x, 639));
      w.row = 9'(project_axis(py, pz, focal_y, centre_y, 479));
      s = nx * nx + ny * ny + nz * nz;
      w.r = shade(nx, s);
      w.g = shade(ny, s);
      w.b = shade(nz, s);
      w.wr = 1;
      return w;
   endfunction

   always @(posedge clock) begin
      pixel_word_type e;
      if (reset) begin
         focal_x <= pnpc_pkg::FOCAL_X_RST;
         focal_y <= pnpc_pkg::FOCAL_Y_RST;
         centre_x <= pnpc_pkg::CENTRE_X_RST;
         centre_y <= pnpc_pkg::CENTRE_Y_RST;
         pixel_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (pnpc_pkg::csr_reg_type'(csr_addr))
               pnpc_pkg::REG_FOCAL_X:  focal_x <= csr_wdata;
               pnpc_pkg::REG_FOCAL_Y:  focal_y <= csr_wdata;
               pnpc_pkg::REG_CENTRE_X: centre_x <= csr_wdata;
               pnpc_pkg::REG_CENTRE_Y: centre_y <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            pixel_queue.push_back(predict_pixel(req_pos_x, req_pos_y, req_pos_z,
               req_norm_x, req_norm_y, req_norm_z, req_point_ok));
         if (rsp_valid && rsp_ready) begin
            if (pixel_queue.size() == 0) begin
               $display("%0t: unexpected word col=%0d row=%0d", $time,
                        rsp_pixel_col, rsp_pixel_row);
               fail_count <= fail_count + 1;
            end else begin
               e = pixel_queue.pop_front();
               if ({rsp_pixel_col, rsp_pixel_row, rsp_red, rsp_green, rsp_blue,
                    rsp_write_pixel} !== e) begin
                  $display("%0t: expected col=%0d row=%0d rgb=%0d,%0d,%0d wr=%0d", $time,
                           e.col, e.row, e.r, e.g, e.b, e.wr);
                  $display("%0t: actual   col=%0d row=%0d rgb=%0d,%0d,%0d wr=%0d", $time,
                           rsp_pixel_col, rsp_pixel_row, rsp_red, rsp_green, rsp_blue,
                           rsp_write_pixel);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top: drives points, normals and camera registers and reports the verdict.
`timescale 1ns / 1ps
module tb_top;

   localparam int WATCHDOG = 20000;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0, csr_valid = 0;
   logic signed [pnpc_pkg::POS_W-1:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic signed [pnpc_pkg::NORM_W-1:0] req_norm_x = 0, req_norm_y = 0, req_norm_z = 0;
   logic req_point_ok = 0;
   logic [pnpc_pkg::CSR_ADDR_W-1:0] csr_addr = 0;
   logic [pnpc_pkg::REG_W-1:0] csr_wdata = 0;
   logic req_ready, rsp_valid, csr_ready, rsp_write_pixel;
   logic [9:0] rsp_pixel_col;
   logic [8:0] rsp_pixel_row;
   logic [pnpc_pkg::COLOR_W-1:0] rsp_red, rsp_green, rsp_blue;
   int fail_count, pending;
   int send_idle = 0, recv_stall = 0, idle_cycles = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   point_normal_to_pixel_color dut (.*);

   pnpc_checker chk (.*);

   // receiver stall
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall);

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // valid stays high between back-to-back words; it drops for idle gaps and in drain
   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [15:0] nx, logic [15:0] ny, logic [15:0] nz, bit ok);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_valid <= 1;
      req_pos_x <= x; req_pos_y <= y; req_pos_z <= z;
      req_norm_x <= nx; req_norm_y <= ny; req_norm_z <= nz;
      req_point_ok <= ok;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (pnpc_pkg::PIPE_DEPTH + 4) @(posedge clock);
   endtask

   task automatic write_reg(pnpc_pkg::csr_reg_type idx, logic [pnpc_pkg::REG_W-1:0] val);
      csr_valid <= 1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic random_point;
      logic [31:0] x, y, z;
      logic [15:0] nx, ny, nz;
      x = $urandom; y = $urandom; z = $urandom;
      nx = 16'($urandom); ny = 16'($urandom); nz = 16'($urandom);
      case ($urandom_range(3))
         1: begin  // realistic scene: a metre or so in front of the camera
            x = $signed($urandom_range(131072)) - 65536;
            y = $signed($urandom_range(131072)) - 65536;
            z = $urandom_range(200000, 10000);
         end
         2: begin
            x = $signed($urandom_range(2000)) - 1000;
            y = $signed($urandom_range(2000)) - 1000;
            z = $signed($urandom_range(400)) - 200;
            nx = 16'($signed($urandom_range(32768)) - 16384);
            ny = 16'($signed($urandom_range(32768)) - 16384);
            nz = 16'($signed($urandom_range(32768)) - 16384);
         end
         3: if ($urandom_range(1)) z = 0; else {nx, ny, nz} = '0;
         default: ;
      endcase
      send_point(x, y, z, nx, ny, nz, $urandom_range(9) != 0);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, invalid point, zero depth, zero normal, negative depth
      send_point(0, 0, 32'sd65536, 16'sd16384, 0, 0, 1);
      send_point(32'h7fffffff, 32'h7fffffff, 1, 16'h7fff, 16'h7fff, 16'h7fff, 1);
      send_point(32'h80000000, 32'h80000000, 1, 16'h8000, 16'h8000, 16'h8000, 1);
      send_point(32'h80000000, 32'h7fffffff, 32'h80000000, 16'h8000, 0, 16'h7fff, 1);
      send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 16'h7fff, 16'h8000, 1);
      send_point(100, 200, 0, 1, 2, 3, 1);
      send_point(100, 200, 300, 1, 2, 3, 0);
      send_point(32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff, 16'hffff, 0);
      send_point(65536, 65536, 65536, 0, 0, 0, 1);
      send_point(-65536, -65536, -65536, 0, 16'sd16384, 0, 1);
      send_point(-32768, 32768, 65536, 0, 0, -16384, 1);
      send_point(1, -1, -1, 1, -1, 1, 1);
      drain();

      write_reg(pnpc_pkg::REG_FOCAL_X, '0);
      write_reg(pnpc_pkg::REG_FOCAL_Y, '0);
      write_reg(pnpc_pkg::REG_CENTRE_X, '0);
      write_reg(pnpc_pkg::REG_CENTRE_Y, '0);
      repeat (5) random_point();
      send_point(1000, 1000, -500, 3, 4, 5, 1);
      drain();
      write_reg(pnpc_pkg::REG_FOCAL_X, '1);
      write_reg(pnpc_pkg::REG_FOCAL_Y, '1);
      write_reg(pnpc_pkg::REG_CENTRE_X, '1);
      write_reg(pnpc_pkg::REG_CENTRE_Y, '1);
      repeat (5) random_point();
      drain();
      write_reg(pnpc_pkg::REG_FOCAL_X, pnpc_pkg::FOCAL_X_RST);
      write_reg(pnpc_pkg::REG_FOCAL_Y, pnpc_pkg::FOCAL_Y_RST);
      write_reg(pnpc_pkg::REG_CENTRE_X, pnpc_pkg::CENTRE_X_RST);
      write_reg(pnpc_pkg::REG_CENTRE_Y, pnpc_pkg::CENTRE_Y_RST);

      for (int phase = 0; phase < 5; phase++) begin
         case (phase % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 65; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 65; end
            default: begin send_idle = 17; recv_stall = 17; end
         endcase
         repeat (100) random_point();
         drain();
         send_idle = 0; recv_stall = 0;
         write_reg(pnpc_pkg::csr_reg_type'(phase % 4), pnpc_pkg::REG_W'($urandom));
         write_reg(pnpc_pkg::csr_reg_type'((phase + 1) % 4),
                   pnpc_pkg::REG_W'($urandom_range(200000, 20000)));
      end
      drain();

      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> sim.f
hdl/pnpc_pkg.sv
hdl/pnpc_proj.sv
hdl/pnpc_color.sv
hdl/point_normal_to_pixel_color.sv
hdl/pnpc_check.sv
tb/sv/pnpc_checker.sv
tb/sv/tb_top.sv
